[rtl/stack_push_pull_sequencer_macros.svh]
// Assertion macros shared by the stack push/pull sequencer RTL.
`ifndef STACK_PUSH_PULL_SEQUENCER_MACROS_SVH
`define STACK_PUSH_PULL_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled in reset.
`define SPPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spps assertion failed");

// Next-cycle implication, disabled in reset.
`define SPPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spps assertion failed");

`else

`define SPPS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SPPS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/spps_pkg.sv]
// Shared types, codes and the register decode function for the stack push/pull sequencer.
package spps_pkg;

   typedef enum logic [2:0] {
      OP_SET_SYS  = 3'd0,
      OP_SET_USR  = 3'd1,
      OP_PUSH_SYS = 3'd2,
      OP_PULL_SYS = 3'd3,
      OP_PUSH_USR = 3'd4,
      OP_PULL_USR = 3'd5
   } op_type;

   localparam logic [3:0] REG_CC = 4'd0;
   localparam logic [3:0] REG_A  = 4'd1;
   localparam logic [3:0] REG_B  = 4'd2;
   localparam logic [3:0] REG_DP = 4'd3;
   localparam logic [3:0] REG_X  = 4'd4;
   localparam logic [3:0] REG_Y  = 4'd5;
   localparam logic [3:0] REG_U  = 4'd6;
   localparam logic [3:0] REG_S  = 4'd7;
   localparam logic [3:0] REG_PC = 4'd8;

   localparam logic [1:0] COST_BYTE = 2'd2;
   localparam logic [1:0] COST_WORD = 2'd3;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   typedef struct packed {
      logic accept;   // take the request on the input channel
      logic step;     // emit one transfer into the output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_runs;   // pending request is a push/pull with a nonempty mask
      logic last_bit;   // one mask bit left in the working mask
      logic slot_free;  // output register can take a transfer this cycle
      logic mask_live;  // working mask is nonzero
   } ctrl_status_type;

   // Mask bit position to register code; bit 6 names the other stack pointer.
   function automatic logic [3:0] reg_code(input logic [2:0] bit_idx, input logic user);
      logic [3:0] code;
      case (bit_idx)
         3'd0: code = REG_CC;
         3'd1: code = REG_A;
         3'd2: code = REG_B;
         3'd3: code = REG_DP;
         3'd4: code = REG_X;
         3'd5: code = REG_Y;
         3'd6: code = user ? REG_S : REG_U;
         3'd7: code = REG_PC;
         default: code = REG_CC;
      endcase
      return code;
   endfunction

endpackage

[rtl/spps_ctrl.sv]
// Sequencing state machine: request acceptance and per-transfer stepping.
`include "stack_push_pull_sequencer_macros.svh"

module spps_ctrl
   import spps_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid && status.req_runs) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = status.slot_free;
            if (status.slot_free && status.last_bit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A run always has a transfer left to emit.
   `SPPS_ASSERT_IMPL(a_run_has_work, clock, reset, state_ff == ST_RUN, status.mask_live)

endmodule

[rtl/spps_dp.sv]
// Datapath: stack pointers, working mask, transfer decode and output register.
`include "stack_push_pull_sequencer_macros.svh"

module spps_dp
   import spps_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status,
   input  logic [23:0]     req_tdata,
   input  logic [2:0]      req_tuser,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [31:0]     rsp_tdata,
   output logic            rsp_tlast
);

   logic [15:0] sys_ptr_ff;
   logic [15:0] usr_ptr_ff;
   logic [7:0]  work_mask_ff;
   logic        is_push_ff;
   logic        is_user_ff;
   logic [4:0]  total_ff;

   logic        out_valid_ff;
   logic [15:0] out_addr_ff;
   logic        out_write_ff;
   logic [3:0]  out_code_ff;
   logic        out_word_ff;
   logic [1:0]  out_cost_ff;
   logic [4:0]  out_total_ff;
   logic        out_last_ff;

   logic [2:0]  operation;
   logic [7:0]  reg_mask;
   logic [15:0] pointer_value;
   logic        op_is_xfer;

   logic [2:0]  bit_idx;
   logic        word;
   logic [1:0]  cost;
   logic [15:0] cur_ptr;
   logic [15:0] xfer_addr;
   logic [15:0] ptr_in;
   logic [7:0]  mask_rem;
   logic [4:0]  total_in;

   assign operation     = req_tuser;
   assign reg_mask      = req_tdata[7:0];
   assign pointer_value = req_tdata[23:8];

   always_comb begin
      op_is_xfer = operation inside {OP_PUSH_SYS, OP_PULL_SYS, OP_PUSH_USR, OP_PULL_USR};
   end

   // Next bit: highest set for a push, lowest set for a pull.
   always_comb begin
      bit_idx = 3'd0;
      if (is_push_ff) begin
         for (int i = 0; i < 8; i++) begin
            if (work_mask_ff[i]) bit_idx = 3'(i);
         end
      end else begin
         for (int i = 7; i >= 0; i--) begin
            if (work_mask_ff[i]) bit_idx = 3'(i);
         end
      end
   end

   always_comb begin
      word      = bit_idx[2];
      cost      = word ? COST_WORD : COST_BYTE;
      cur_ptr   = is_user_ff ? usr_ptr_ff : sys_ptr_ff;
      xfer_addr = is_push_ff ? cur_ptr - {14'd0, word, ~word} : cur_ptr;
      ptr_in    = is_push_ff ? xfer_addr : cur_ptr + {14'd0, word, ~word};
      mask_rem  = work_mask_ff;
      mask_rem[bit_idx] = 1'b0;
      total_in  = total_ff + {3'd0, cost};
   end

   assign status.req_runs  = op_is_xfer && (reg_mask != 8'd0);
   assign status.last_bit  = (mask_rem == 8'd0);
   assign status.slot_free = ~out_valid_ff | rsp_tready;
   assign status.mask_live = (work_mask_ff != 8'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         sys_ptr_ff   <= '0;
         usr_ptr_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            if (operation == OP_SET_SYS) sys_ptr_ff <= pointer_value;
            if (operation == OP_SET_USR) usr_ptr_ff <= pointer_value;
         end
         if (cmd.step) begin
            if (is_user_ff) usr_ptr_ff <= ptr_in;
            else            sys_ptr_ff <= ptr_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         work_mask_ff <= reg_mask;
         is_push_ff   <= (operation == OP_PUSH_SYS) || (operation == OP_PUSH_USR);
         is_user_ff   <= (operation == OP_PUSH_USR) || (operation == OP_PULL_USR);
         total_ff     <= '0;
      end else if (cmd.step) begin
         work_mask_ff <= mask_rem;
         total_ff     <= total_in;
      end
      if (cmd.step) begin
         out_addr_ff  <= xfer_addr;
         out_write_ff <= is_push_ff;
         out_code_ff  <= reg_code(bit_idx, is_user_ff);
         out_word_ff  <= word;
         out_cost_ff  <= cost;
         out_total_ff <= total_in;
         out_last_ff  <= (mask_rem == 8'd0);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {3'd0, out_total_ff, out_cost_ff, out_word_ff, out_code_ff,
                        out_write_ff, out_addr_ff};

   `SPPS_ASSERT_NEXT(a_mask_drains, clock, reset, cmd.step && status.last_bit, work_mask_ff == 8'd0)
   `SPPS_ASSERT_NEXT(a_push_ptr_at_addr, clock, reset, cmd.step && is_push_ff, cur_ptr == out_addr_ff)
   `SPPS_ASSERT_IMPL(a_total_covers_cost, clock, reset, out_valid_ff, out_total_ff >= {3'd0, out_cost_ff})

endmodule

[rtl/stack_push_pull_sequencer.sv]
// Top level of the stack push/pull sequencer: controller plus datapath.
//
// Keeps the system (S) and user (U) stack pointers and turns each request
// transaction into a run of memory transfer descriptors. A set operation loads
// a pointer and produces nothing; a push walks the mask from PC down to CC with
// pre-decrement, a pull walks CC up to PC with post-increment, one transfer
// transaction per set mask bit, the final one flagged with rsp_tlast.
// Sequence: an idle controller takes a request, then one transfer is written
// into the output register per cycle while that register can take one; a push
// or pull holds the request side until its last transfer is written. Set
// operations, empty masks and unused operation codes do not start a run. The
// rate is set by the single pointer update and the one-deep output register:
// a stalled rsp side pauses the run. The last transfer of a request may still
// wait in the output register while the next request is taken. Pointers pulled
// from memory are not tracked here; load them afterwards with a set operation.
module stack_push_pull_sequencer
   import spps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] reg_mask, [23:8] pointer_value
   input  logic [23:0] req_tdata,
   // [2:0] operation
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] address, [16] is_write, [20:17] register_code, [21] is_word,
   // [23:22] access_cycles, [28:24] total_cycles, [31:29] zero
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Controller: idle/run sequencing and handshake on the request side.
   spps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: pointers, mask walk, descriptor build and output register.
   spps_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[tb/stack_push_pull_sequencer_tb.sv]
// Self-checking testbench for the stack push/pull transfer sequencer.
module stack_push_pull_sequencer_tb;
   import spps_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_ITEMS = 155;
   localparam int HOLD_AT      = 40;     // random item that starts the long rsp stall
   localparam int HOLD_CYCLES  = 80;
   localparam int PAUSE_AT     = 110;    // random item before which the sender drains
   localparam int TAIL_ITEMS   = 30;     // final stretch with no idling on either side
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;

   // Operation codes the package leaves unnamed; the block must ignore them.
   localparam logic [2:0] OP_UNDEF_6 = 3'd6;
   localparam logic [2:0] OP_UNDEF_7 = 3'd7;

   // How a directed row is checked.
   localparam logic [1:0] ROW_PREDICTED = 2'd0;   // expectation from the predictor
   localparam logic [1:0] ROW_NO_XFER   = 2'd1;   // typed in: nothing comes out
   localparam logic [1:0] ROW_ONE_XFER  = 2'd2;   // typed in: exactly one transfer

   // Register code per mask bit; bit 6 is resolved by which stack is in use.
   localparam logic [3:0] BIT_REG [8] = '{REG_CC, REG_A, REG_B, REG_DP,
                                          REG_X, REG_Y, REG_U, REG_PC};

   typedef struct packed {
      logic [15:0] address;
      logic        is_write;
      logic [3:0]  reg_code;
      logic        is_word;
      logic [1:0]  cost;
      logic [4:0]  total;
      logic        last;
   } xfer_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  mask;
      logic [15:0] pval;
      logic [1:0]  kind;
      xfer_type    want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // [7:0] reg_mask, [23:8] pointer_value
   logic [23:0] req_tdata;
   // [2:0] operation
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [15:0] address, [16] is_write, [20:17] register_code, [21] is_word,
   // [23:22] access_cycles, [28:24] total_cycles, [31:29] zero
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;

   // Predictor state: the two stack pointers as the block should hold them.
   logic [15:0] sys_sp;
   logic [15:0] usr_sp;

   xfer_type fresh_xfers [$];    // transfers worked out for the latest request
   xfer_type pending_xfers [$];  // transfers still owed by the block, oldest first

   int error_count;
   int cycle_count;
   bit quiet_tail;
   bit rsp_hold_wanted;
   bit rsp_holding;

   stack_push_pull_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Directed stimulus. Typed rows track the pointers from reset:
   // sys starts at 0, a one-byte push wraps to FFFF, the pull brings it back.
   localparam int N_ROWS = 25;
   localparam stim_row_type DIRECTED [N_ROWS] = '{
      '{OP_PUSH_SYS, 8'h01, 16'h0000, ROW_ONE_XFER,
        '{16'hFFFF, 1'b1, REG_CC, 1'b0, COST_BYTE, 5'd2, 1'b1}},
      '{OP_PULL_SYS, 8'h01, 16'h0000, ROW_ONE_XFER,
        '{16'hFFFF, 1'b0, REG_CC, 1'b0, COST_BYTE, 5'd2, 1'b1}},
      // set ignores the mask
      '{OP_SET_SYS,  8'hFF, 16'h0001, ROW_NO_XFER, '0},
      // word pre-decrement wraps below zero
      '{OP_PUSH_SYS, 8'h80, 16'h0000, ROW_ONE_XFER,
        '{16'hFFFF, 1'b1, REG_PC, 1'b1, COST_WORD, 5'd3, 1'b1}},
      '{OP_SET_USR,  8'h00, 16'hFFFF, ROW_NO_XFER, '0},
      // word post-increment wraps past FFFF, usr ends at 0001
      '{OP_PULL_USR, 8'h80, 16'h0000, ROW_ONE_XFER,
        '{16'hFFFF, 1'b0, REG_PC, 1'b1, COST_WORD, 5'd3, 1'b1}},
      // other-pointer bit on the user stack names S
      '{OP_PUSH_USR, 8'h40, 16'h0000, ROW_ONE_XFER,
        '{16'hFFFF, 1'b1, REG_S, 1'b1, COST_WORD, 5'd3, 1'b1}},
      // and on the system stack names U
      '{OP_PULL_SYS, 8'h40, 16'h0000, ROW_ONE_XFER,
        '{16'hFFFF, 1'b0, REG_U, 1'b1, COST_WORD, 5'd3, 1'b1}},
      // empty masks and unused codes produce nothing
      '{OP_PUSH_SYS, 8'h00, 16'hFFFF, ROW_NO_XFER, '0},
      '{OP_PULL_USR, 8'h00, 16'h0000, ROW_NO_XFER, '0},
      '{OP_UNDEF_6,  8'hFF, 16'hFFFF, ROW_NO_XFER, '0},
      '{OP_UNDEF_7,  8'h55, 16'h1234, ROW_NO_XFER, '0},
      '{OP_SET_SYS,  8'h00, 16'h0000, ROW_NO_XFER, '0},
      // full masks reach the largest running total
      '{OP_PUSH_SYS, 8'hFF, 16'h0000, ROW_PREDICTED, '0},
      '{OP_PULL_SYS, 8'hFF, 16'h0000, ROW_PREDICTED, '0},
      '{OP_SET_USR,  8'hAA, 16'h8000, ROW_NO_XFER, '0},
      '{OP_PUSH_USR, 8'hFF, 16'h0000, ROW_PREDICTED, '0},
      '{OP_PULL_USR, 8'hFF, 16'h0000, ROW_PREDICTED, '0},
      '{OP_PUSH_SYS, 8'h55, 16'h0000, ROW_PREDICTED, '0},
      '{OP_PULL_USR, 8'hAA, 16'h0000, ROW_PREDICTED, '0},
      '{OP_PUSH_USR, 8'h0F, 16'h0000, ROW_PREDICTED, '0},
      '{OP_PULL_SYS, 8'hF0, 16'h0000, ROW_PREDICTED, '0},
      '{OP_SET_SYS,  8'h00, 16'hFFFF, ROW_NO_XFER, '0},
      '{OP_PULL_SYS, 8'h80, 16'h0000, ROW_ONE_XFER,
        '{16'hFFFF, 1'b0, REG_PC, 1'b1, COST_WORD, 5'd3, 1'b1}},
      '{OP_PUSH_USR, 8'h01, 16'h0000, ROW_PREDICTED, '0}
   };

   // Works out the transfers of one accepted request into fresh_xfers and
   // updates the pointer copies.
   function automatic void predict_request(input logic [2:0] op, input logic [7:0] mask,
                                           input logic [15:0] pval);
      logic [15:0] sp;
      logic [4:0]  total;
      logic        on_user;
      logic        is_push;
      logic        word;
      xfer_type    x;
      int          b;
      fresh_xfers.delete();
      case (op)
         OP_SET_SYS: begin
            sys_sp = pval;
            return;
         end
         OP_SET_USR: begin
            usr_sp = pval;
            return;
         end
         OP_PUSH_SYS, OP_PULL_SYS, OP_PUSH_USR, OP_PULL_USR: ;
         default: return;
      endcase
      on_user = (op == OP_PUSH_USR) || (op == OP_PULL_USR);
      is_push = (op == OP_PUSH_SYS) || (op == OP_PUSH_USR);
      sp = on_user ? usr_sp : sys_sp;
      total = '0;
      for (int k = 0; k < 8; k++) begin
         b = is_push ? 7 - k : k;
         if (mask[b]) begin
            word = (b >= 4);
            if (is_push) sp = sp - (word ? 16'd2 : 16'd1);
            x.address  = sp;
            x.is_write = is_push;
            x.reg_code = (b == 6) ? (on_user ? REG_S : REG_U) : BIT_REG[b];
            x.is_word  = word;
            x.cost     = word ? COST_WORD : COST_BYTE;
            total      = total + 5'(x.cost);
            x.total    = total;
            x.last     = 1'b0;
            fresh_xfers.push_back(x);
            if (!is_push) sp = sp + (word ? 16'd2 : 16'd1);
         end
      end
      if (on_user) usr_sp = sp;
      else sys_sp = sp;
      if (fresh_xfers.size() > 0) fresh_xfers[fresh_xfers.size() - 1].last = 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got_v, want_v);
      error_count++;
   endtask

   // Offers one request, holds it until taken, then queues what it owes.
   // tvalid is left high; the caller lowers it only when a gap follows.
   task automatic send_request(input logic [2:0] op, input logic [7:0] mask,
                               input logic [15:0] pval, input logic [1:0] kind,
                               input xfer_type typed);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {pval, mask};
      do @(posedge clock); while (!req_tready);
      predict_request(op, mask, pval);
      if (kind == ROW_PREDICTED) begin
         foreach (fresh_xfers[i]) pending_xfers.push_back(fresh_xfers[i]);
      end else if (kind == ROW_ONE_XFER) begin
         pending_xfers.push_back(typed);
      end
   endtask

   // Random sender gap, skipped often so that back-to-back stretches occur;
   // never during the rsp stall or the quiet tail.
   task automatic maybe_idle_sender();
      int n;
      if (quiet_tail || rsp_holding || $urandom_range(0, 3) != 0) return;
      n = $urandom_range(1, 10);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Random request: mostly pushes and pulls with varied masks, some pointer
   // loads to move the stacks around, a few unused codes.
   task automatic random_request(output logic [2:0] op, output logic [7:0] mask,
                                 output logic [15:0] pval);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) op = OP_SET_SYS;
      else if (pick < 16) op = OP_SET_USR;
      else if (pick < 21) op = $urandom_range(0, 1) ? OP_UNDEF_7 : OP_UNDEF_6;
      else op = 3'($urandom_range(OP_PUSH_SYS, OP_PULL_USR));
      pick = $urandom_range(0, 99);
      if (pick < 8) mask = 8'h00;
      else if (pick < 25) mask = 8'(1 << $urandom_range(0, 7));
      else if (pick < 35) mask = 8'hFF;
      else mask = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8) pval = 16'h0000;
      else if (pick < 16) pval = 16'hFFFF;
      else pval = 16'($urandom);
   endtask

   // Result side: bursts of ready and stall, one long hold on request, and
   // steady ready in the tail.
   initial begin : rsp_side
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_wanted) begin
            rsp_hold_wanted = 1'b0;
            rsp_holding     = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_holding = 1'b0;
         end else if (quiet_tail) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   // Checks every transfer transaction against the oldest one owed.
   always @(posedge clock) begin : xfer_check
      xfer_type got;
      xfer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[15:0], rsp_tdata[16], rsp_tdata[20:17], rsp_tdata[21],
                 rsp_tdata[23:22], rsp_tdata[28:24], rsp_tlast};
         if (pending_xfers.size() == 0) begin
            report_mismatch("transfer with nothing pending, address", got.address, 0);
         end else begin
            want = pending_xfers.pop_front();
            if (got.address != want.address)
               report_mismatch("address", got.address, want.address);
            if (got.is_write != want.is_write)
               report_mismatch("is_write", got.is_write, want.is_write);
            if (got.reg_code != want.reg_code)
               report_mismatch("register_code", got.reg_code, want.reg_code);
            if (got.is_word != want.is_word)
               report_mismatch("is_word", got.is_word, want.is_word);
            if (got.cost != want.cost)
               report_mismatch("access_cycles", got.cost, want.cost);
            if (got.total != want.total)
               report_mismatch("total_cycles", got.total, want.total);
            if (got.last != want.last)
               report_mismatch("last", got.last, want.last);
         end
      end
   end

   // Watchdog on a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("stack_push_pull_sequencer_tb failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [2:0]  op;
      logic [7:0]  mask;
      logic [15:0] pval;
      error_count = 0;
      cycle_count = 0;
      sys_sp = '0;
      usr_sp = '0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) begin
         maybe_idle_sender();
         send_request(DIRECTED[i].op, DIRECTED[i].mask, DIRECTED[i].pval,
                      DIRECTED[i].kind, DIRECTED[i].want);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == HOLD_AT) rsp_hold_wanted = 1'b1;
         if (i == RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
         if (i == PAUSE_AT) begin
            // sender goes quiet until the block has delivered everything
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending_xfers.size() != 0);
         end else begin
            maybe_idle_sender();
         end
         random_request(op, mask, pval);
         send_request(op, mask, pval, ROW_PREDICTED, '0);
      end

      req_tvalid <= 1'b0;
      while (pending_xfers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("stack_push_pull_sequencer_tb passed");
      end else begin
         $display("stack_push_pull_sequencer_tb failed");
      end
      $finish;
   end

endmodule

[stack_push_pull_sequencer.f]
+incdir+rtl
rtl/spps_pkg.sv
rtl/spps_ctrl.sv
rtl/spps_dp.sv
rtl/stack_push_pull_sequencer.sv
tb/stack_push_pull_sequencer_tb.sv
